>>> rtl/core/rgbbox_pkg.sv
`timescale 1ns / 1ps

package rgbbox_pkg;

  localparam int unsigned ImageSideMax = 4096;
  localparam int unsigned SideW        = 13;
  localparam int unsigned TermW        = 9;
  localparam int unsigned TallW        = 14;
  localparam int unsigned SumW         = 34;
  localparam int unsigned AreaW        = 26;
  localparam int unsigned QuoW         = 14;
  localparam int unsigned LumaAccW     = 24;
  localparam int unsigned StepW        = 4;

  localparam logic [StepW-1:0] StepsCols = 4'd13;
  localparam logic [StepW-1:0] StepsRows = 4'd12;
  localparam logic [StepW-1:0] StepsAvg  = 4'd8;

  localparam logic [15:0] LumaCoefRed   = 16'd13933;
  localparam logic [15:0] LumaCoefGreen = 16'd46871;
  localparam logic [15:0] LumaCoefBlue  = 16'd4732;

  localparam logic [SideW-1:0] ResetImageCols = 13'd640;
  localparam logic [SideW-1:0] ResetImageRows = 13'd480;
  localparam logic [TermW-1:0] ResetTermCols  = 9'd120;
  localparam logic [TermW-1:0] ResetTermRows  = 9'd30;

  typedef enum logic [1:0] {
    REG_IMAGE_COLS = 2'd0,
    REG_IMAGE_ROWS = 2'd1,
    REG_TERM_COLS  = 2'd2,
    REG_TERM_ROWS  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    DIV_COLS,
    DIV_ROWS,
    DIV_RED,
    DIV_GREEN,
    DIV_BLUE
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_e div_sel;
    logic     size_set;
    logic     area_set;
    logic     mem_rd;
    logic     update;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic frame_start;
    logic close;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/rgbbox_ram.sv
`timescale 1ns / 1ps

module rgbbox_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rgbbox_ctrl.sv
`timescale 1ns / 1ps

module rgbbox_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rgbbox_pkg::sts_t  sts_i,
  output rgbbox_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLS_GO,
    ST_COLS_WAIT,
    ST_ROWS_GO,
    ST_ROWS_WAIT,
    ST_SIZE,
    ST_AREA,
    ST_READ,
    ST_UPDATE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_GREEN_GO,
    ST_GREEN_WAIT,
    ST_BLUE_GO,
    ST_BLUE_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == ST_IDLE);
  assign in_stall_o = !ready;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = rgbbox_pkg::DIV_COLS;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = sts_i.frame_start ? ST_COLS_GO : ST_READ;
        end
      end
      ST_COLS_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = rgbbox_pkg::DIV_COLS;
        state_d       = ST_COLS_WAIT;
      end
      ST_COLS_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_ROWS_GO;
        end
      end
      ST_ROWS_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = rgbbox_pkg::DIV_ROWS;
        state_d       = ST_ROWS_WAIT;
      end
      ST_ROWS_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_o.size_set = 1'b1;
        state_d        = ST_AREA;
      end
      ST_AREA: begin
        cmd_o.area_set = 1'b1;
        state_d        = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.close ? ST_RED_GO : ST_IDLE;
      end
      ST_RED_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = rgbbox_pkg::DIV_RED;
        state_d       = ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_GREEN_GO;
        end
      end
      ST_GREEN_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = rgbbox_pkg::DIV_GREEN;
        state_d       = ST_GREEN_WAIT;
      end
      ST_GREEN_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_BLUE_GO;
        end
      end
      ST_BLUE_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = rgbbox_pkg::DIV_BLUE;
        state_d       = ST_BLUE_WAIT;
      end
      ST_BLUE_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/rgbbox_dp.sv
`timescale 1ns / 1ps

module rgbbox_dp #(
  parameter int unsigned MAX_CELLS_ACROSS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [rgbbox_pkg::SideW-1:0]       cfg_wdata_i,
  input  logic [7:0]                         red_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         blue_i,
  input  rgbbox_pkg::cmd_t                   cmd_i,
  output rgbbox_pkg::sts_t                   sts_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [7:0]                         cell_row_o,
  output logic [7:0]                         cell_col_o,
  output logic [7:0]                         red_avg_o,
  output logic [7:0]                         green_avg_o,
  output logic [7:0]                         blue_avg_o,
  output logic [7:0]                         luma_o
);

  localparam int unsigned SideW    = rgbbox_pkg::SideW;
  localparam int unsigned TermW    = rgbbox_pkg::TermW;
  localparam int unsigned TallW    = rgbbox_pkg::TallW;
  localparam int unsigned SumW     = rgbbox_pkg::SumW;
  localparam int unsigned AreaW    = rgbbox_pkg::AreaW;
  localparam int unsigned QuoW     = rgbbox_pkg::QuoW;
  localparam int unsigned AccW     = rgbbox_pkg::LumaAccW;
  localparam int unsigned StepW    = rgbbox_pkg::StepW;
  localparam int unsigned GridCap  = (MAX_CELLS_ACROSS < 256) ? MAX_CELLS_ACROSS : 256;
  localparam int unsigned AddrW    = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int unsigned WordW    = 3 * SumW;

  // Configuration registers.
  logic [SideW-1:0] cols_q, rows_q;
  logic [TermW-1:0] tc_q, tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= rgbbox_pkg::ResetImageCols;
      rows_q <= rgbbox_pkg::ResetImageRows;
      tc_q   <= rgbbox_pkg::ResetTermCols;
      tr_q   <= rgbbox_pkg::ResetTermRows;
    end else if (cfg_we_i) begin
      case (rgbbox_pkg::reg_idx_e'(cfg_index_i))
        rgbbox_pkg::REG_IMAGE_COLS: cols_q <= cfg_wdata_i;
        rgbbox_pkg::REG_IMAGE_ROWS: rows_q <= cfg_wdata_i;
        rgbbox_pkg::REG_TERM_COLS:  tc_q   <= cfg_wdata_i[TermW-1:0];
        rgbbox_pkg::REG_TERM_ROWS:  tr_q   <= cfg_wdata_i[TermW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [SideW-1:0] cols_c, rows_c;
  logic [TermW-1:0] tc_c, tr_c;
  logic [7:0]       tc_last, tr_last;

  assign cols_c = (cols_q == '0) ? SideW'(1) :
                  (cols_q > SideW'(rgbbox_pkg::ImageSideMax)) ?
                  SideW'(rgbbox_pkg::ImageSideMax) : cols_q;
  assign rows_c = (rows_q == '0) ? SideW'(1) :
                  (rows_q > SideW'(rgbbox_pkg::ImageSideMax)) ?
                  SideW'(rgbbox_pkg::ImageSideMax) : rows_q;
  assign tc_c   = (tc_q == '0) ? TermW'(1) : (tc_q > TermW'(GridCap)) ? TermW'(GridCap) : tc_q;
  assign tr_c   = (tr_q == '0) ? TermW'(1) : (tr_q > TermW'(GridCap)) ? TermW'(GridCap) : tr_q;
  assign tc_last = 8'(tc_c - TermW'(1));
  assign tr_last = 8'(tr_c - TermW'(1));

  // Pixel and position state.
  logic [7:0]       pix_r_q, pix_g_q, pix_b_q;
  logic [SideW-1:0] col_q, row_q, scol_q, cxr_q, cyr_q;
  logic [TallW-1:0] srow_q, bt_q;
  logic [SideW-1:0] bw_q;
  logic [QuoW-1:0]  a_q, b_q;
  logic [AreaW-1:0] area_q;

  logic [7:0] cx, cy;
  logic       last_col, last_row, scol_end, srow_end, right, bottom, close;

  assign cx = (cxr_q > SideW'(tc_last)) ? tc_last : cxr_q[7:0];
  assign cy = (cyr_q > SideW'(tr_last)) ? tr_last : cyr_q[7:0];

  assign last_col = ({1'b0, col_q} + 14'd1) >= {1'b0, cols_c};
  assign last_row = ({1'b0, row_q} + 14'd1) >= {1'b0, rows_c};
  assign scol_end = (scol_q == (bw_q - SideW'(1)));
  assign srow_end = (srow_q == (bt_q - TallW'(1)));
  assign right    = last_col || scol_end;
  assign bottom   = last_row || srow_end;
  assign close    = right && bottom;

  logic [TallW-1:0] max_ab, bt_d;
  logic [SideW-1:0] bw_d;
  logic [26:0]      area_full;

  assign max_ab    = (a_q > b_q) ? a_q : b_q;
  assign bt_d      = max_ab + TallW'(1);
  assign bw_d      = (bt_d[TallW-1:1] == '0) ? SideW'(1) : bt_d[TallW-1:1];
  assign area_full = 27'(bt_q) * 27'(bw_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_r_q <= red_i;
      pix_g_q <= green_i;
      pix_b_q <= blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      scol_q <= '0;
      srow_q <= '0;
      cxr_q  <= '0;
      cyr_q  <= '0;
      bt_q   <= '0;
      bw_q   <= '0;
      area_q <= '0;
    end else begin
      if (cmd_i.size_set) begin
        bt_q <= bt_d;
        bw_q <= bw_d;
      end
      if (cmd_i.area_set) begin
        area_q <= area_full[AreaW-1:0];
      end
      if (cmd_i.update) begin
        if (last_col) begin
          col_q  <= '0;
          scol_q <= '0;
          cxr_q  <= '0;
          if (last_row) begin
            row_q  <= '0;
            srow_q <= '0;
            cyr_q  <= '0;
          end else begin
            row_q <= row_q + SideW'(1);
            if (srow_end) begin
              srow_q <= '0;
              cyr_q  <= cyr_q + SideW'(1);
            end else begin
              srow_q <= srow_q + TallW'(1);
            end
          end
        end else begin
          col_q <= col_q + SideW'(1);
          if (scol_end) begin
            scol_q <= '0;
            cxr_q  <= cxr_q + SideW'(1);
          end else begin
            scol_q <= scol_q + SideW'(1);
          end
        end
      end
    end
  end

  // Accumulator line: memory plus one valid bit per entry.
  logic [AddrW-1:0]            addr;
  logic [MAX_CELLS_ACROSS-1:0] vld_q;
  logic                        vld_rd_q;
  logic [WordW-1:0]            ram_rdata, ram_wdata;
  logic [SumW-1:0]             base_r, base_g, base_b, new_r, new_g, new_b;
  logic                        ram_we;

  assign addr   = AddrW'(cx);
  assign base_r = vld_rd_q ? ram_rdata[3*SumW-1:2*SumW] : '0;
  assign base_g = vld_rd_q ? ram_rdata[2*SumW-1:SumW]   : '0;
  assign base_b = vld_rd_q ? ram_rdata[SumW-1:0]        : '0;
  assign new_r  = base_r + SumW'(pix_r_q);
  assign new_g  = base_g + SumW'(pix_g_q);
  assign new_b  = base_b + SumW'(pix_b_q);
  assign ram_wdata = {new_r, new_g, new_b};
  assign ram_we    = cmd_i.update && !close;

  rgbbox_ram #(
    .Width (WordW),
    .Depth (MAX_CELLS_ACROSS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.size_set) begin
        vld_q <= '0;
      end else if (cmd_i.update) begin
        vld_q[addr] <= !close;
      end
      if (cmd_i.mem_rd) begin
        vld_rd_q <= vld_q[addr];
      end
    end
  end

  logic [SumW-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [7:0]      cell_x_q, cell_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && close) begin
      sum_r_q  <= new_r;
      sum_g_q  <= new_g;
      sum_b_q  <= new_b;
      cell_x_q <= cx;
      cell_y_q <= cy;
    end
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [SumW-1:0]       rem_q, dsh_q;
  logic [QuoW-1:0]       quo_q;
  logic [StepW-1:0]      cnt_q;
  logic                  busy_q, done_q;
  rgbbox_pkg::div_sel_e  sel_q;
  logic                  fits;

  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sel_q  <= rgbbox_pkg::DIV_COLS;
    end else begin
      done_q <= busy_q && (cnt_q == '0) && !cmd_i.div_go;
      if (cmd_i.div_go) begin
        busy_q <= 1'b1;
        sel_q  <= cmd_i.div_sel;
        case (cmd_i.div_sel)
          rgbbox_pkg::DIV_COLS: cnt_q <= rgbbox_pkg::StepsCols;
          rgbbox_pkg::DIV_ROWS: cnt_q <= rgbbox_pkg::StepsRows;
          default:              cnt_q <= rgbbox_pkg::StepsAvg;
        endcase
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      quo_q <= '0;
      case (cmd_i.div_sel)
        rgbbox_pkg::DIV_COLS: begin
          rem_q <= SumW'({cols_c, 1'b0});
          dsh_q <= SumW'(tc_c) << rgbbox_pkg::StepsCols;
        end
        rgbbox_pkg::DIV_ROWS: begin
          rem_q <= SumW'(rows_c);
          dsh_q <= SumW'(tr_c) << rgbbox_pkg::StepsRows;
        end
        rgbbox_pkg::DIV_RED: begin
          rem_q <= sum_r_q;
          dsh_q <= SumW'(area_q) << rgbbox_pkg::StepsAvg;
        end
        rgbbox_pkg::DIV_GREEN: begin
          rem_q <= sum_g_q;
          dsh_q <= SumW'(area_q) << rgbbox_pkg::StepsAvg;
        end
        default: begin
          rem_q <= sum_b_q;
          dsh_q <= SumW'(area_q) << rgbbox_pkg::StepsAvg;
        end
      endcase
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QuoW-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  // Averages and luma.
  logic [7:0]      avg, avg_r_q, avg_g_q, avg_b_q;
  logic [15:0]     coef;
  logic [AccW-1:0] prod, acc_q;

  assign avg  = quo_q[8] ? 8'hFF : quo_q[7:0];
  assign prod = AccW'(coef) * AccW'(avg);

  always_comb begin
    case (sel_q)
      rgbbox_pkg::DIV_RED:   coef = rgbbox_pkg::LumaCoefRed;
      rgbbox_pkg::DIV_GREEN: coef = rgbbox_pkg::LumaCoefGreen;
      default:               coef = rgbbox_pkg::LumaCoefBlue;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (done_q) begin
      case (sel_q)
        rgbbox_pkg::DIV_COLS: a_q <= quo_q;
        rgbbox_pkg::DIV_ROWS: b_q <= quo_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_q) begin
      case (sel_q)
        rgbbox_pkg::DIV_RED: begin
          avg_r_q <= avg;
          acc_q   <= prod;
        end
        rgbbox_pkg::DIV_GREEN: begin
          avg_g_q <= avg;
          acc_q   <= acc_q + prod;
        end
        rgbbox_pkg::DIV_BLUE: begin
          avg_b_q <= avg;
          acc_q   <= acc_q + prod;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  logic       out_valid_q;
  logic [7:0] o_row_q, o_col_q, o_r_q, o_g_q, o_b_q, o_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_row_q <= cell_y_q;
      o_col_q <= cell_x_q;
      o_r_q   <= avg_r_q;
      o_g_q   <= avg_g_q;
      o_b_q   <= avg_b_q;
      o_y_q   <= acc_q[AccW-1:AccW-8];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_row_o  = o_row_q;
  assign cell_col_o  = o_col_q;
  assign red_avg_o   = o_r_q;
  assign green_avg_o = o_g_q;
  assign blue_avg_o  = o_b_q;
  assign luma_o      = o_y_q;

  assign sts_o.frame_start = (col_q == '0) && (row_q == '0);
  assign sts_o.close       = close;
  assign sts_o.div_done    = done_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_go |-> !busy_q) else $error("divider started while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i)) else $error("result overwritten");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q) else $error("emitted beat not shown");

endmodule

>>> rtl/core/rgb_box_downscale_luma.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Beat
// config    in         cfg_we_i                cfg_index_i, cfg_wdata_i
// pixel     in         in_valid_i / in_stall_o red_i, green_i, blue_i
// cell      out        out_valid_o / out_stall_i cell_row_o, cell_col_o, *_avg_o, luma_o
//
// A pixel that closes no cell passes through load, read and update; one that closes a cell
// also runs three restoring divisions of nine steps each and waits for a free output register.
// The first pixel of a frame adds the two block size divisions and the size and area steps.
// Reset clears all accumulators through per-entry valid bits; no clearing pass.
// A waiting result sits in the output register while the next pixel is taken.

module rgb_box_downscale_luma #(
  parameter int unsigned MAX_CELLS_ACROSS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [rgbbox_pkg::SideW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   red_i,
  input  logic [7:0]                   green_i,
  input  logic [7:0]                   blue_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   cell_row_o,
  output logic [7:0]                   cell_col_o,
  output logic [7:0]                   red_avg_o,
  output logic [7:0]                   green_avg_o,
  output logic [7:0]                   blue_avg_o,
  output logic [7:0]                   luma_o
);

  rgbbox_pkg::cmd_t cmd;
  rgbbox_pkg::sts_t sts;

  rgbbox_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rgbbox_dp #(
    .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cell_row_o  (cell_row_o),
    .cell_col_o  (cell_col_o),
    .red_avg_o   (red_avg_o),
    .green_avg_o (green_avg_o),
    .blue_avg_o  (blue_avg_o),
    .luma_o      (luma_o)
  );

endmodule
